/* rtl/core/twelve_bit_accumulator_cpu_macros.svh */
// ----------------------------------------------------------------------------
// twelve_bit_accumulator_cpu_macros
// Assertion macros used by the processor top level.
// ----------------------------------------------------------------------------
`ifndef TWELVE_BIT_ACCUMULATOR_CPU_MACROS_SVH
`define TWELVE_BIT_ACCUMULATOR_CPU_MACROS_SVH

// same-cycle implication, checked out of reset
`define TBA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tba assertion failed");

// next-cycle implication, checked out of reset
`define TBA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tba assertion failed");

`endif

/* rtl/core/tba_pkg.sv */
// ----------------------------------------------------------------------------
// tba_pkg
// Widths, codes and controller interface types of the accumulator processor.
// ----------------------------------------------------------------------------
package tba_pkg;

   localparam int WORD_W    = 12;
   localparam int FIELD_W   = 3;
   localparam int ADDR_W    = 15;
   localparam int MEM_WORDS = 32768;
   localparam int MADDR_W   = $clog2(MEM_WORDS);
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 72;

   // item kinds
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;
   localparam logic [1:0] FUNC_EXEC  = 2'd3;

   // major opcodes
   localparam logic [2:0] OP_AND = 3'd0;
   localparam logic [2:0] OP_TAD = 3'd1;
   localparam logic [2:0] OP_ISZ = 3'd2;
   localparam logic [2:0] OP_DCA = 3'd3;
   localparam logic [2:0] OP_JMS = 3'd4;
   localparam logic [2:0] OP_JMP = 3'd5;
   localparam logic [2:0] OP_IOT = 3'd6;
   localparam logic [2:0] OP_OPR = 3'd7;

   // processor iot operations
   localparam logic [2:0] IOT_SKON = 3'd0;
   localparam logic [2:0] IOT_ION  = 3'd1;
   localparam logic [2:0] IOT_IOF  = 3'd2;
   localparam logic [2:0] IOT_SRQ  = 3'd3;
   localparam logic [2:0] IOT_GTF  = 3'd4;
   localparam logic [2:0] IOT_RTF  = 3'd5;
   localparam logic [2:0] IOT_SGT  = 3'd6;
   localparam logic [2:0] IOT_CAF  = 3'd7;

   // group 1 rotate codes
   localparam logic [2:0] ROT_NONE = 3'd0;
   localparam logic [2:0] ROT_BSW  = 3'd1;
   localparam logic [2:0] ROT_RAL  = 3'd2;
   localparam logic [2:0] ROT_RTL  = 3'd3;
   localparam logic [2:0] ROT_RAR  = 3'd4;
   localparam logic [2:0] ROT_RTR  = 3'd5;
   localparam logic [2:0] ROT_AND  = 3'd6;
   localparam logic [2:0] ROT_PAGE = 3'd7;

   // one phase of the sequencer at a time
   typedef struct packed {
      logic latch;
      logic start;
      logic fetch;
      logic decode;
      logic ptr;
      logic oper;
      logic exec;
      logic finish;
   } tba_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       halted;
      logic       intr_go;
      logic [2:0] op;
      logic       ind;
      logic       out_free;
   } tba_status_type;

endpackage

/* rtl/core/tba_ctrl.sv */
// ----------------------------------------------------------------------------
// tba_ctrl
// Sequencer: steps each item through start, fetch, decode, pointer, operand, execute and finish phases.
// ----------------------------------------------------------------------------
module tba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  tba_pkg::tba_status_type st,
   output tba_pkg::tba_cmd_type    cmd
);
   import tba_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_START  = 8'b0000_0010,
      S_FETCH  = 8'b0000_0100,
      S_DECODE = 8'b0000_1000,
      S_PTR    = 8'b0001_0000,
      S_OPER   = 8'b0010_0000,
      S_EXEC   = 8'b0100_0000,
      S_FIN    = 8'b1000_0000
   } tba_state_type;

   tba_state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // phase commands
   always_comb begin
      cmd        = '0;
      cmd.latch  = (state_ff == S_IDLE) && req_tvalid;
      cmd.start  = (state_ff == S_START);
      cmd.fetch  = (state_ff == S_FETCH);
      cmd.decode = (state_ff == S_DECODE);
      cmd.ptr    = (state_ff == S_PTR);
      cmd.oper   = (state_ff == S_OPER);
      cmd.exec   = (state_ff == S_EXEC);
      cmd.finish = (state_ff == S_FIN) && st.out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_START;
         end
         S_START: begin
            if (st.func == FUNC_EXEC && !st.halted) state_in = S_FETCH;
            else state_in = S_FIN;
         end
         S_FETCH: state_in = S_DECODE;
         S_DECODE: begin
            if (st.op == OP_IOT || st.op == OP_OPR) state_in = S_FIN;
            else if (st.ind) state_in = S_PTR;
            else state_in = S_OPER;
         end
         S_PTR: state_in = S_OPER;
         S_OPER: begin
            if (st.op == OP_AND || st.op == OP_TAD || st.op == OP_ISZ) state_in = S_EXEC;
            else state_in = S_FIN;
         end
         S_EXEC: state_in = S_FIN;
         S_FIN: begin
            if (st.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

/* rtl/core/tba_dpath.sv */
// ----------------------------------------------------------------------------
// tba_dpath
// Registers, word memory, instruction execution and the result register.
// ----------------------------------------------------------------------------
module tba_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  tba_pkg::tba_cmd_type             cmd,
   output tba_pkg::tba_status_type          st,
   input  logic [1:0]                       req_tuser,
   input  logic [tba_pkg::REQ_W-1:0]        req_tdata,
   input  logic                             csr_valid,
   input  logic [tba_pkg::WORD_W-1:0]       csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tba_pkg::RSP_W-1:0]        rsp_tdata
);
   import tba_pkg::*;

   // word memory
   logic [WORD_W-1:0] mem_ff [MEM_WORDS];
   logic [WORD_W-1:0] memq_ff;
   logic              memq_ok_ff;
   logic [WORD_W-1:0] memq;

   // latched request
   logic [1:0]         func_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [WORD_W-1:0]  data_ff;
   logic               irqln_ff;

   // architectural state
   logic [WORD_W-1:0]  ac_ff, ac_in, pc_ff, pc_in, mq_ff, mq_in, sw_ff;
   logic               lk_ff, lk_in;
   logic [FIELD_W-1:0] if_ff, if_in, df_ff, df_in, ifb_ff, ifb_in;
   logic               um_ff, um_in, umb_ff, umb_in;
   logic [6:0]         sf_ff, sf_in;
   logic               ie_ff, ie_in, ied_ff, ied_in, iej_ff, iej_in;
   logic               utp_ff, utp_in, halt_ff, halt_in;

   // per-instruction working registers
   logic [WORD_W-1:0]  mb_ff, mb_in, ea_ff, ea_in;
   logic [FIELD_W-1:0] ef_ff, ef_in;
   logic               irq_ff, irq_in;
   logic               intr_ff, intr_in, dev_ff, dev_in, trap_ff, trap_in;
   logic [5:0]         dcode_ff, dcode_in;
   logic [2:0]         dop_ff, dop_in;

   // result register
   logic               ov_ff;
   logic [RSP_W-1:0]   out_ff;

   // memory port controls
   logic               wen, ren;
   logic [ADDR_W-1:0]  waddr, raddr;
   logic [WORD_W-1:0]  wdata;

   assign memq = memq_ok_ff ? memq_ff : '0;

   // status to the sequencer
   always_comb begin
      st          = '0;
      st.func     = func_ff;
      st.halted   = halt_ff;
      st.intr_go  = (irqln_ff | utp_ff) & ied_ff & iej_ff;
      st.op       = cmd.decode ? memq[11:9] : mb_ff[11:9];
      st.ind      = cmd.decode ? memq[8] : mb_ff[8];
      st.out_free = !ov_ff || rsp_tready;
   end

   // execution
   always_comb begin
      logic [WORD_W-1:0] a, q, ptr, pcp1;
      logic [12:0]       v, s;
      logic              l, c, irq;
      logic [2:0]        op;

      ac_in = ac_ff;  pc_in = pc_ff;  mq_in = mq_ff;  lk_in = lk_ff;
      if_in = if_ff;  df_in = df_ff;  ifb_in = ifb_ff;
      um_in = um_ff;  umb_in = umb_ff; sf_in = sf_ff;
      ie_in = ie_ff;  ied_in = ied_ff; iej_in = iej_ff;
      utp_in = utp_ff; halt_in = halt_ff;
      mb_in = mb_ff;  ea_in = ea_ff;  ef_in = ef_ff;  irq_in = irq_ff;
      intr_in = intr_ff; dev_in = dev_ff; trap_in = trap_ff;
      dcode_in = dcode_ff; dop_in = dop_ff;
      wen = 1'b0; ren = 1'b0;
      waddr = '0; raddr = '0; wdata = '0;
      q    = memq;
      pcp1 = pc_ff + 12'd1;
      op   = mb_ff[11:9];
      a = '0; ptr = '0; v = '0; s = '0; l = 1'b0; c = 1'b0; irq = 1'b0;

      unique if (cmd.latch) begin
         intr_in = 1'b0; dev_in = 1'b0; trap_in = 1'b0;
         dcode_in = '0; dop_in = '0;
      end else if (cmd.start) begin
         unique case (func_ff)
            FUNC_LOAD: begin
               wen = 1'b1; waddr = addr_ff; wdata = data_ff;
            end
            FUNC_READ: begin
               ren = 1'b1; raddr = addr_ff;
            end
            FUNC_START: begin
               pc_in   = addr_ff[11:0];
               if_in   = addr_ff[14:12];
               ifb_in  = addr_ff[14:12];
               df_in   = addr_ff[14:12];
               halt_in = 1'b0;
            end
            default: begin
               if (!halt_ff) begin
                  irq    = irqln_ff | utp_ff;
                  irq_in = irq;
                  ied_in = ie_ff;
                  // interrupt entry saves pc in word zero of field zero
                  if (irq && ied_ff && iej_ff) begin
                     wen = 1'b1; waddr = '0; wdata = pc_ff;
                     pc_in  = 12'd1;
                     sf_in  = {um_ff, if_ff, df_ff};
                     if_in  = '0; ifb_in = '0; df_in = '0;
                     um_in  = 1'b0; umb_in = 1'b0;
                     ie_in  = 1'b0; ied_in = 1'b0;
                     intr_in = 1'b1;
                  end
               end
            end
         endcase
      end else if (cmd.fetch) begin
         ren = 1'b1; raddr = {if_ff, pc_ff};
      end else if (cmd.decode) begin
         mb_in = q;
         op    = q[11:9];
         unique case (op)
            OP_IOT: begin
               pc_in = pcp1;
               if (um_ff) begin
                  utp_in = 1'b1; trap_in = 1'b1;
               end else if (q[8:3] != 6'd0) begin
                  dev_in = 1'b1; dcode_in = q[8:3]; dop_in = q[2:0];
               end else begin
                  unique case (q[2:0])
                     IOT_SKON: begin
                        if (ie_ff) pc_in = pc_ff + 12'd2;
                        ie_in = 1'b0; ied_in = 1'b0;
                     end
                     IOT_ION: ie_in = 1'b1;
                     IOT_IOF: begin
                        ie_in = 1'b0; ied_in = 1'b0;
                     end
                     IOT_SRQ: begin
                        if (irq_ff) pc_in = pc_ff + 12'd2;
                     end
                     IOT_GTF: ac_in = {lk_ff, 1'b0, irq_ff, 1'b0, ie_ff, sf_ff};
                     IOT_RTF: begin
                        lk_in  = ac_ff[11];
                        ie_in  = 1'b1;
                        umb_in = ac_ff[6];
                        ifb_in = ac_ff[5:3];
                        df_in  = ac_ff[2:0];
                        iej_in = 1'b0;
                     end
                     IOT_SGT: ;
                     default: begin
                        lk_in = 1'b0; ac_in = '0; utp_in = 1'b0;
                        ie_in = 1'b0; ied_in = 1'b0;
                     end
                  endcase
               end
            end
            OP_OPR: begin
               pc_in = pcp1;
               if (!q[8]) begin
                  // group 1: clear, complement, increment, then rotate, byte swap, mask or page address
                  a = ac_ff; l = lk_ff;
                  if (q[7]) a = '0;
                  if (q[6]) l = 1'b0;
                  if (q[5]) a = ~a;
                  if (q[4]) l = ~l;
                  if (q[0]) {l, a} = {l, a} + 13'd1;
                  v = {l, a};
                  unique case (q[3:1])
                     ROT_BSW:  v = {v[12], v[5:0], v[11:6]};
                     ROT_RAL:  v = {v[11:0], v[12]};
                     ROT_RTL:  v = {v[10:0], v[12:11]};
                     ROT_RAR:  v = {v[0], v[12:1]};
                     ROT_RTR:  v = {v[1:0], v[12:2]};
                     ROT_AND:  v = {v[12], v[11:0] & q};
                     ROT_PAGE: v = {v[12], pc_ff & 12'o7600 | {5'd0, q[6:0]}};
                     default:  ;
                  endcase
                  lk_in = v[12]; ac_in = v[11:0];
               end else if (!q[0]) begin
                  // group 2: skips, then clear, switches and halt
                  c = (q[6] && ac_ff[11]) || (q[5] && ac_ff == '0) || (q[4] && lk_ff);
                  if (q[3]) c = !c;
                  if (c) pc_in = pc_ff + 12'd2;
                  a = q[7] ? '0 : ac_ff;
                  if (um_ff && q[2:1] != 2'd0) begin
                     utp_in = 1'b1; trap_in = 1'b1;
                  end else begin
                     if (q[2]) a = a | sw_ff;
                     if (q[1]) halt_in = 1'b1;
                  end
                  ac_in = a;
               end else begin
                  // group 3: mq transfers
                  a = q[7] ? '0 : ac_ff;
                  ac_in = a;
                  unique case ({q[6], q[4]})
                     2'b10: ac_in = a | mq_ff;
                     2'b01: begin
                        mq_in = a; ac_in = '0;
                     end
                     2'b11: begin
                        mq_in = a; ac_in = mq_ff;
                     end
                     default: ;
                  endcase
               end
            end
            default: begin
               // memory reference: form the effective address
               ea_in = {(q[7] ? pc_ff[11:7] : 5'd0), q[6:0]};
               ef_in = if_ff;
               if (op != OP_JMS && op != OP_JMP) pc_in = pcp1;
               if (q[8]) begin
                  ren = 1'b1; raddr = {if_ff, q[7] ? pc_ff[11:7] : 5'd0, q[6:0]};
               end
            end
         endcase
      end else if (cmd.ptr) begin
         // indirect pointer, with autoindex on words 010 to 017
         ptr = q;
         if (ea_ff[11:3] == 9'o001) begin
            ptr = q + 12'd1;
            wen = 1'b1; waddr = {ef_ff, ea_ff}; wdata = ptr;
         end
         ea_in = ptr;
         ef_in = (op == OP_JMS || op == OP_JMP) ? if_ff : df_ff;
      end else if (cmd.oper) begin
         unique case (op)
            OP_AND, OP_TAD, OP_ISZ: begin
               ren = 1'b1; raddr = {ef_ff, ea_ff};
            end
            OP_DCA: begin
               wen = 1'b1; waddr = {ef_ff, ea_ff}; wdata = ac_ff;
               ac_in = '0;
            end
            OP_JMS: begin
               if_in = ifb_ff; um_in = umb_ff; iej_in = 1'b1;
               wen = 1'b1; waddr = {ifb_ff, ea_ff}; wdata = pcp1;
               pc_in = ea_ff + 12'd1;
            end
            default: begin
               if_in = ifb_ff; um_in = umb_ff; iej_in = 1'b1;
               pc_in = ea_ff;
            end
         endcase
      end else if (cmd.exec) begin
         unique case (op)
            OP_AND: ac_in = ac_ff & q;
            OP_TAD: begin
               s = {lk_ff, ac_ff} + {1'b0, q};
               lk_in = s[12]; ac_in = s[11:0];
            end
            default: begin
               a = q + 12'd1;
               wen = 1'b1; waddr = {ef_ff, ea_ff}; wdata = a;
               if (a == '0) pc_in = pcp1;
            end
         endcase
      end else begin
      end
   end

   // memory, read data registered
   always_ff @(posedge clock) begin
      if (wen && ({1'b0, waddr} < (ADDR_W+1)'(MEM_WORDS)))
         mem_ff[waddr[MADDR_W-1:0]] <= wdata;
      if (ren) begin
         memq_ff    <= mem_ff[raddr[MADDR_W-1:0]];
         memq_ok_ff <= ({1'b0, raddr} < (ADDR_W+1)'(MEM_WORDS));
      end
   end

   // request latch and working registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff  <= req_tuser;
         addr_ff  <= req_tdata[14:0];
         data_ff  <= req_tdata[26:15];
         irqln_ff <= req_tdata[27];
      end
      mb_ff <= mb_in; ea_ff <= ea_in; ef_ff <= ef_in; irq_ff <= irq_in;
      intr_ff <= intr_in; dev_ff <= dev_in; trap_ff <= trap_in;
      dcode_ff <= dcode_in; dop_ff <= dop_in;
   end

   // architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ac_ff <= '0; pc_ff <= '0; mq_ff <= '0; lk_ff <= 1'b0; sw_ff <= '0;
         if_ff <= '0; df_ff <= '0; ifb_ff <= '0;
         um_ff <= 1'b0; umb_ff <= 1'b0; sf_ff <= '0;
         ie_ff <= 1'b0; ied_ff <= 1'b0; iej_ff <= 1'b0;
         utp_ff <= 1'b0; halt_ff <= 1'b1;
      end else begin
         ac_ff <= ac_in; pc_ff <= pc_in; mq_ff <= mq_in; lk_ff <= lk_in;
         if_ff <= if_in; df_ff <= df_in; ifb_ff <= ifb_in;
         um_ff <= um_in; umb_ff <= umb_in; sf_ff <= sf_in;
         ie_ff <= ie_in; ied_ff <= ied_in; iej_ff <= iej_in;
         utp_ff <= utp_in; halt_ff <= halt_in;
         if (csr_valid) sw_ff <= csr_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (cmd.finish) ov_ff <= 1'b1;
      else if (rsp_tready) ov_ff <= 1'b0;
      if (cmd.finish)
         out_ff <= {7'd0, trap_ff, dop_ff, dcode_ff, dev_ff, intr_ff, halt_ff,
                    (func_ff == FUNC_READ) ? memq : 12'd0,
                    mq_ff, lk_ff, ac_ff, if_ff, pc_ff};
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

endmodule

/* rtl/core/twelve_bit_accumulator_cpu.sv */
// ----------------------------------------------------------------------------
// twelve_bit_accumulator_cpu
// Twelve-bit accumulator processor with banked word memory, one item at a time.
// ----------------------------------------------------------------------------
//   channel   direction  handshake           payload
//   req_      in         req_tvalid/tready   tuser func, tdata address/data/irq
//   rsp_      out        rsp_tvalid/tready   tdata registers and flags
//   csr_      in         csr_valid/ready     switch register word
//
// load, read and start items, and execute items while halted, pass through the
// start and finish phases; an instruction also passes fetch and decode, then for
// memory reference an optional pointer read, the operand phase and, for and, tad
// and isz, execute. reset leaves the processor halted.
// a result waits in its own register; a new beat is taken while it is stalled,
// and the sequencer only holds at its last phase if the register is still full.
module twelve_bit_accumulator_cpu (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [1:0]                  req_tuser,  // func
   input  logic [tba_pkg::REQ_W-1:0]   req_tdata,  // address, data, irq_line
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // pc_out, ifield_out, ac_out, link_out, mq_out, read_word, halted,
   // interrupt_taken, device_iot, device_code, device_op, user_trap
   output logic [tba_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tba_pkg::WORD_W-1:0]  csr_data
);
   import tba_pkg::*;
   `include "twelve_bit_accumulator_cpu_macros.svh"

   tba_cmd_type    cmd;
   tba_status_type st;

   assign csr_ready = 1'b1;

   tba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   tba_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // checks
   `TBA_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `TBA_ASSERT_NEXT(a_result_loaded, cmd.finish, rsp_tvalid)
   `TBA_ASSERT_SAME(a_finish_has_room, cmd.finish, !rsp_tvalid || rsp_tready)

endmodule

/* tb/twelve_bit_accumulator_cpu_tb.sv */
// ----------------------------------------------------------------------------
// twelve_bit_accumulator_cpu_tb
// Self-checking bench for the twelve-bit accumulator processor. A stimulus
// process plans load, read, start and execute beats and runs its own copy of
// the processor, so every planned beat carries the response it must produce.
// Memory is filled on demand, so no instruction ever touches a word that was
// never written. Both channels idle at random, and the response side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module twelve_bit_accumulator_cpu_tb;
   import tba_pkg::*;

   typedef struct packed {
      logic [1:0]  func;
      logic [14:0] addr;
      logic [11:0] data;
      logic        irq;
   } cpu_item_type;

   // response word, most significant field first
   typedef struct packed {
      logic [6:0]  pad;
      logic        trap;
      logic [2:0]  dop;
      logic [5:0]  dcode;
      logic        dev;
      logic        intr;
      logic        halted;
      logic [11:0] rword;
      logic [11:0] mq;
      logic        link;
      logic [11:0] ac;
      logic [2:0]  ifield;
      logic [11:0] pc;
   } cpu_state_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [1:0]          req_tuser = '0;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [WORD_W-1:0]   csr_data = '0;

   cpu_item_type  item_q[$];
   cpu_state_type due_q[$];
   int         mismatches = 0;
   int         beats_in = 0;
   int         beats_out = 0;
   int         squeeze_left = 0;
   bit         squeeze_done = 0;
   bit         calm = 0;
   int         n_plan = 0;
   int         n_exec = 0, n_intr = 0, n_trap = 0, n_dev = 0;

   // shadow processor state
   logic [11:0] img[MEM_WORDS];
   bit          seen[MEM_WORDS];
   int          seen_list[$];
   logic [11:0] s_ac, s_pc, s_mq, s_sw;
   logic        s_link, s_um, s_umb, s_ie, s_ied, s_iej, s_trp, s_hlt;
   logic [2:0]  s_if, s_df, s_ifb;
   logic [6:0]  s_sf;

   twelve_bit_accumulator_cpu uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // memory write in the shadow, marks the word as written
   function automatic void put_word(logic [2:0] fld, logic [11:0] off, logic [11:0] v);
      logic [14:0] a;
      a = {fld, off};
      img[a] = v;
      if (!seen[a]) begin
         seen[a] = 1;
         seen_list.push_back(int'(a));
      end
   endfunction

   function automatic logic [11:0] get_word(logic [2:0] fld, logic [11:0] off);
      return img[{fld, off}];
   endfunction

   // address of the next fetch, -1 when halted
   function automatic int fetch_addr(logic irq_in);
      if (s_hlt) return -1;
      if ((irq_in | s_trp) && s_ied && s_iej) return 1;
      return int'({s_if, s_pc});
   endfunction

   // first word the next instruction reads that was never written, else -1
   function automatic int unwritten_word(logic irq_in);
      logic [11:0] pc, mb, ea, ptr;
      logic [2:0]  fi, df, op, ef;
      logic [14:0] a;
      int          fa;
      fa = fetch_addr(irq_in);
      if (fa < 0) return -1;
      a = 15'(fa);
      fi = a[14:12];
      pc = a[11:0];
      df = (fa == 1 && s_ied && s_iej && (irq_in | s_trp)) ? 3'd0 : s_df;
      if (!seen[a]) return int'(a);
      mb = img[a];
      op = mb[11:9];
      if (op >= OP_IOT) return -1;
      ea = {(mb[7] ? pc[11:7] : 5'd0), mb[6:0]};
      ef = fi;
      if (mb[8]) begin
         a = {fi, ea};
         if (!seen[a]) return int'(a);
         ptr = img[a];
         if (ea[11:3] == 9'd1) ptr = ptr + 12'd1;
         ea = ptr;
         ef = (op < OP_JMS) ? df : fi;
      end
      if (op <= OP_ISZ) begin
         a = {ef, ea};
         if (!seen[a]) return int'(a);
      end
      return -1;
   endfunction

   // one beat through the shadow processor
   function automatic cpu_state_type cpu_predict(cpu_item_type it);
      cpu_state_type r;
      logic [11:0] mb, ea, ptr, v, t;
      logic [2:0]  op, ef;
      logic [12:0] la;
      logic        irq, c;
      r = '0;
      case (it.func)
         FUNC_LOAD: put_word(it.addr[14:12], it.addr[11:0], it.data);
         FUNC_READ: r.rword = img[it.addr];
         FUNC_START: begin
            s_pc = it.addr[11:0];
            s_if = it.addr[14:12];
            s_ifb = s_if;
            s_df = s_if;
            s_hlt = 0;
         end
         default: if (!s_hlt) begin
            irq = it.irq | s_trp;
            // interrupt entry before the fetch
            if (irq && s_ied && s_iej) begin
               put_word(3'd0, 12'd0, s_pc);
               s_pc = 12'd1;
               s_sf = {s_um, s_if, s_df};
               s_if = 0; s_ifb = 0; s_df = 0;
               s_um = 0; s_umb = 0;
               s_ie = 0;
               r.intr = 1;
            end
            s_ied = s_ie;
            mb = get_word(s_if, s_pc);
            op = mb[11:9];
            if (op < OP_IOT) begin
               // memory reference
               ea = {(mb[7] ? s_pc[11:7] : 5'd0), mb[6:0]};
               ef = s_if;
               if (op < OP_JMS) s_pc = s_pc + 12'd1;
               if (mb[8]) begin
                  ptr = get_word(ef, ea);
                  if (ea[11:3] == 9'd1) begin
                     ptr = ptr + 12'd1;
                     put_word(ef, ea, ptr);
                  end
                  ea = ptr;
                  ef = (op < OP_JMS) ? s_df : s_if;
               end
               case (op)
                  OP_AND: s_ac = s_ac & get_word(ef, ea);
                  OP_TAD: {s_link, s_ac} = {s_link, s_ac} + {1'b0, get_word(ef, ea)};
                  OP_ISZ: begin
                     v = get_word(ef, ea) + 12'd1;
                     put_word(ef, ea, v);
                     if (v == 0) s_pc = s_pc + 12'd1;
                  end
                  OP_DCA: begin
                     put_word(ef, ea, s_ac);
                     s_ac = 0;
                  end
                  OP_JMS: begin
                     s_if = s_ifb; s_um = s_umb; s_iej = 1;
                     put_word(s_if, ea, s_pc + 12'd1);
                     s_pc = ea + 12'd1;
                  end
                  default: begin
                     s_if = s_ifb; s_um = s_umb; s_iej = 1;
                     s_pc = ea;
                  end
               endcase
            end else if (op == OP_IOT) begin
               s_pc = s_pc + 12'd1;
               if (s_um) begin
                  s_trp = 1;
                  r.trap = 1;
               end else if (mb[8:3] != 0) begin
                  r.dev = 1;
                  r.dcode = mb[8:3];
                  r.dop = mb[2:0];
               end else begin
                  case (mb[2:0])
                     IOT_SKON: begin
                        if (s_ie) s_pc = s_pc + 12'd1;
                        s_ie = 0; s_ied = 0;
                     end
                     IOT_ION: s_ie = 1;
                     IOT_IOF: begin s_ie = 0; s_ied = 0; end
                     IOT_SRQ: if (irq) s_pc = s_pc + 12'd1;
                     IOT_GTF: s_ac = {s_link, 1'b0, irq, 1'b0, s_ie, s_sf};
                     IOT_RTF: begin
                        s_link = s_ac[11];
                        s_ie = 1;
                        s_umb = s_ac[6];
                        s_ifb = s_ac[5:3];
                        s_df = s_ac[2:0];
                        s_iej = 0;
                     end
                     IOT_SGT: ;
                     default: begin
                        s_link = 0; s_ac = 0; s_trp = 0; s_ie = 0; s_ied = 0;
                     end
                  endcase
               end
            end else if (!mb[8]) begin
               // group 1
               s_pc = s_pc + 12'd1;
               if (mb[7]) s_ac = 0;
               if (mb[6]) s_link = 0;
               if (mb[5]) s_ac = ~s_ac;
               if (mb[4]) s_link = ~s_link;
               if (mb[0]) {s_link, s_ac} = {s_link, s_ac} + 13'd1;
               la = {s_link, s_ac};
               case (mb[3:1])
                  ROT_BSW:  s_ac = {s_ac[5:0], s_ac[11:6]};
                  ROT_RAL:  la = {la[11:0], la[12]};
                  ROT_RTL:  la = {la[10:0], la[12:11]};
                  ROT_RAR:  la = {la[0], la[12:1]};
                  ROT_RTR:  la = {la[1:0], la[12:2]};
                  ROT_AND:  s_ac = s_ac & mb;
                  ROT_PAGE: begin
                     t = s_pc - 12'd1;
                     s_ac = {t[11:7], mb[6:0]};
                  end
                  default: ;
               endcase
               if (mb[3:1] inside {ROT_RAL, ROT_RTL, ROT_RAR, ROT_RTR})
                  {s_link, s_ac} = la;
            end else if (!mb[0]) begin
               // group 2
               c = 0;
               s_pc = s_pc + 12'd1;
               if (mb[6] && s_ac[11]) c = 1;
               if (mb[5] && s_ac == 0) c = 1;
               if (mb[4] && s_link) c = 1;
               if (mb[3]) c = !c;
               if (c) s_pc = s_pc + 12'd1;
               if (mb[7]) s_ac = 0;
               if (s_um && (mb[2] | mb[1])) begin
                  s_trp = 1;
                  r.trap = 1;
               end else begin
                  if (mb[2]) s_ac = s_ac | s_sw;
                  if (mb[1]) s_hlt = 1;
               end
            end else begin
               // group 3
               s_pc = s_pc + 12'd1;
               if (mb[7]) s_ac = 0;
               case ({mb[6], mb[4]})
                  2'b10: s_ac = s_ac | s_mq;
                  2'b01: begin s_mq = s_ac; s_ac = 0; end
                  2'b11: begin t = s_mq; s_mq = s_ac; s_ac = t; end
                  default: ;
               endcase
            end
         end
      endcase
      r.pc = s_pc;
      r.ifield = s_if;
      r.ac = s_ac;
      r.link = s_link;
      r.mq = s_mq;
      r.halted = s_hlt;
      return r;
   endfunction

   // plan one beat: run the shadow and queue the beat with its response
   function automatic void plan(logic [1:0] f, logic [14:0] a, logic [11:0] d, logic irq);
      cpu_item_type  it;
      cpu_state_type r;
      it = '{func: f, addr: a, data: d, irq: irq};
      r = cpu_predict(it);
      n_plan++;
      if (f == FUNC_EXEC) begin
         n_exec++;
         n_intr += r.intr;
         n_trap += r.trap;
         n_dev += r.dev;
      end
      item_q.push_back(it);
      due_q.push_back(r);
   endfunction

   // execute a given word: place it at the fetch address if place is set, fill reads, run
   function automatic void plan_exec(logic [11:0] word, logic irq, bit place);
      int a;
      a = fetch_addr(irq);
      if (a >= 0 && place) plan(FUNC_LOAD, 15'(a), word, 1'b0);
      a = unwritten_word(irq);
      while (a >= 0) begin
         plan(FUNC_LOAD, 15'(a), 12'($urandom), 1'b0);
         a = unwritten_word(irq);
      end
      plan(FUNC_EXEC, 15'($urandom), 12'($urandom), irq);
   endfunction

   // random instruction word, weighted to keep the processor running
   function automatic logic [11:0] pick_instr();
      int          k;
      logic [11:0] w;
      k = $urandom_range(0, 99);
      w = 12'($urandom);
      if (k < 45) return {3'($urandom_range(0, 5)), w[8:0]};
      if (k < 65) return {4'o16, w[7:0]};
      if (k < 77) begin
         if ($urandom_range(0, 3) != 0) w[1] = 0;
         return {4'o17, w[7:1], 1'b0};
      end
      if (k < 85) return {4'o17, w[7:1], 1'b1};
      if (k < 95) return {9'o600, 3'($urandom_range(0, 7))};
      return {3'o6, w[8:0]};
   endfunction

   // wait for all beats answered, then let the block settle
   task automatic drain();
      while (item_q.size() != 0 || due_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_switches(logic [11:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      s_sw = v;
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      static int gap = 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            void'(item_q.pop_front());
            beats_in++;
         end
         if (gap > 0) begin
            gap--;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(0, 18);
            req_tvalid <= 1'b0;
         end else if (item_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser <= item_q[0].func;
            req_tdata <= {4'd0, item_q[0].irq, item_q[0].data, item_q[0].addr};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long hold-off on the response side, once
   always @(posedge clock) begin
      if (squeeze_left > 0)
         squeeze_left <= squeeze_left - 1;
      else if (!squeeze_done && beats_in >= 120) begin
         squeeze_left <= 400;
         squeeze_done <= 1;
      end
   end

   // response monitor and ready driver
   always @(posedge clock) begin : watch_rsp
      static int stall = 0;
      cpu_state_type got, want;
      int unsigned ev[12], av[12];
      string nm[12];
      bit bad;
      if (rsp_tvalid && rsp_tready && !reset) begin
         beats_out++;
         got = rsp_tdata;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response beat %0d with none expected", beats_out);
         end else begin
            want = due_q.pop_front();
            nm = '{"pc", "ifield", "ac", "link", "mq", "read_word", "halted",
                   "interrupt_taken", "device_iot", "device_code", "device_op", "user_trap"};
            ev = '{want.pc, want.ifield, want.ac, want.link, want.mq, want.rword,
                   want.halted, want.intr, want.dev, want.dcode, want.dop, want.trap};
            av = '{got.pc, got.ifield, got.ac, got.link, got.mq, got.rword,
                   got.halted, got.intr, got.dev, got.dcode, got.dop, got.trap};
            bad = 0;
            foreach (nm[i]) if (ev[i] != av[i]) begin
               if (!bad) mismatches++;
               bad = 1;
               if (mismatches <= 10)
                  $display("beat %0d %s: expected %o got %o", beats_out, nm[i], ev[i], av[i]);
            end
         end
      end
      if (reset) rsp_tready <= 1'b0;
      else if (squeeze_left > 0) rsp_tready <= 1'b0;
      else if (stall > 0) begin
         stall--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         stall = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   initial begin
      #4000000;
      $display("twelve_bit_accumulator_cpu: mismatch");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      logic [11:0] sw_set[4];
      int k, a, stop;
      s_ac = 0; s_pc = 0; s_mq = 0; s_sw = 0;
      s_link = 0; s_um = 0; s_umb = 0; s_ie = 0; s_ied = 0; s_iej = 0; s_trp = 0;
      s_hlt = 1;
      s_if = 0; s_df = 0; s_ifb = 0; s_sf = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_switches(12'o0100);

      // directed: halted, read, start, addressing, interrupt, user trap
      plan(FUNC_EXEC, 15'o77777, 12'o7777, 1'b1);
      plan(FUNC_LOAD, 15'o77777, 12'o7777, 1'b0);
      plan(FUNC_READ, 15'o77777, 12'd0, 1'b0);
      plan(FUNC_START, 15'o10200, 12'd0, 1'b0);
      plan_exec(12'o7604, 1'b0, 1'b1);          // cla osr
      plan_exec(12'o1410, 1'b0, 1'b1);          // tad through autoindex
      plan_exec(12'o4020, 1'b0, 1'b1);          // page-zero jms
      plan_exec(12'o6001, 1'b0, 1'b1);          // ion
      plan_exec(12'o7000, 1'b0, 1'b1);
      plan_exec(12'o7000, 1'b1, 1'b1);          // interrupt entry
      plan_exec(12'o7604, 1'b0, 1'b1);
      plan_exec(12'o6005, 1'b0, 1'b1);          // rtf into user mode
      plan_exec(12'o5377, 1'b0, 1'b1);
      plan_exec(12'o6001, 1'b0, 1'b1);          // trapped iot
      plan_exec(12'o6007, 1'b0, 1'b1);          // interrupt from the trap, then caf
      plan_exec(12'o6321, 1'b0, 1'b1);          // other device
      plan_exec(12'o6004, 1'b0, 1'b1);          // gtf
      plan_exec(12'o7521, 1'b0, 1'b1);          // swp
      plan_exec(12'o7002, 1'b0, 1'b1);          // bsw
      plan_exec(12'o7016, 1'b0, 1'b1);          // page address
      plan_exec(12'o7402, 1'b0, 1'b1);          // hlt
      plan_exec(12'o7000, 1'b0, 1'b1);          // while halted
      drain();

      // random phases over several switch settings
      sw_set = '{12'o0000, 12'o7777, 12'($urandom), 12'($urandom)};
      for (int ph = 0; ph < 4; ph++) begin
         set_switches(sw_set[ph]);
         if (ph == 3) calm = 1;
         stop = n_plan + 140;
         while (n_plan < stop) begin
            k = $urandom_range(0, 99);
            if (s_hlt && k < 90) plan(FUNC_START, 15'($urandom), 12'd0, 1'b0);
            else if (k < 8 && seen_list.size() > 0) begin
               a = seen_list[$urandom_range(0, seen_list.size() - 1)];
               plan(FUNC_READ, 15'(a), 12'($urandom), 1'($urandom));
            end else if (k < 12) plan(FUNC_START, 15'($urandom), 12'd0, 1'b0);
            else if (k < 16) plan(FUNC_LOAD, 15'($urandom), 12'($urandom), 1'b0);
            else plan_exec(pick_instr(), $urandom_range(0, 3) == 0,
                           $urandom_range(0, 3) != 0);
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("%0d beats in, %0d responses; %0d instructions, %0d interrupts,",
               beats_in, beats_out, n_exec, n_intr);
      $display("%0d user traps, %0d device iots, over five switch settings",
               n_trap, n_dev);
      if (mismatches == 0) $display("twelve_bit_accumulator_cpu: match");
      else $display("twelve_bit_accumulator_cpu: mismatch");
      $finish;
   end

endmodule
